// ----- sv/synth_voice_allocator_core_macros.svh -----
// Assertion macros used by the voice allocator RTL.
`ifndef SYNTH_VOICE_ALLOCATOR_CORE_MACROS_SVH
`define SYNTH_VOICE_ALLOCATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define SVA_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked at every rising edge outside reset.
`define SVA_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`else
`define SVA_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define SVA_ASSERT_NXT(lbl, ck, rn, ante, cons, msg)
`endif

`endif

// ----- sv/svalloc_pkg.sv -----
// Shared types and constants of the voice allocator.
`default_nettype none

package svalloc_pkg;

	localparam int VOICE_COUNT = 18;
	localparam int VSEL_W      = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

	localparam int FUNC_W  = 2;
	localparam int CHAN_W  = 4;
	localparam int NOTE_W  = 7;
	localparam int VOICE_W = 6;
	localparam int AGE_W   = 32;

	localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_ALL_OFF = 2'd2;

	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PW    = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

	localparam int RESQ_DEPTH = 4;
	localparam int RESQ_PW    = (RESQ_DEPTH > 1) ? $clog2(RESQ_DEPTH) : 1;
	localparam int RESQ_CW    = $clog2(RESQ_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_ALLOC,
		OP_RELEASE,
		OP_ALL_OFF
	} op_t;

	typedef enum logic [1:0] {
		ACT_GRANT   = 2'd0,
		ACT_STEAL   = 2'd1,
		ACT_RELEASE = 2'd2
	} act_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_ALLOC,
		BK_STEAL,
		BK_GRANT,
		BK_FREE,
		BK_FLUSH
	} bk_state_t;

	typedef struct packed {
		op_t               op;
		logic [CHAN_W-1:0] channel;
		logic [NOTE_W-1:0] note;
	} cmd_t;

	typedef struct packed {
		logic [VOICE_W-1:0] voice;
		act_t               action;
		logic               last;
	} res_t;

	typedef struct packed {
		logic idle;
	} bk_stat_t;

endpackage

`default_nettype wire

// ----- sv/svalloc_front.sv -----
// Front end: accepts requests, decodes the function and queues commands.
`default_nettype none

module svalloc_front
	import svalloc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [FUNC_W-1:0] func,
	input  logic [CHAN_W-1:0] channel,
	input  logic [NOTE_W-1:0] note,
	output logic              cmd_valid,
	output cmd_t              cmd,
	input  logic              cmd_take
);

	cmd_t               mem_q [CMDQ_DEPTH];
	logic [CMDQ_PW-1:0] wr_ptr_q;
	logic [CMDQ_PW-1:0] rd_ptr_q;
	logic [CMDQ_CW-1:0] count_q;
	logic               known;
	logic               wr_en;
	logic               rd_en;
	cmd_t               dec;

	// Unused function codes are taken and dropped here.
	always_comb begin
		known   = 1'b1;
		dec.op  = OP_ALLOC;
		dec.channel = channel;
		dec.note    = note;
		case (func)
			FUNC_ALLOC:   dec.op = OP_ALLOC;
			FUNC_RELEASE: dec.op = OP_RELEASE;
			FUNC_ALL_OFF: dec.op = OP_ALL_OFF;
			default:      known  = 1'b0;
		endcase
	end

	assign full      = (count_q == CMDQ_CW'(CMDQ_DEPTH));
	assign cmd_valid = (count_q != '0);
	assign cmd       = mem_q[rd_ptr_q];
	assign wr_en     = push && !full && known;
	assign rd_en     = cmd_take && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == CMDQ_PW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == CMDQ_PW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= dec;
		end
	end

endmodule

`default_nettype wire

// ----- sv/svalloc_back.sv -----
// Back end: voice table and the scan engine, one voice per cycle unless a full result queue stalls it.
`default_nettype none

module svalloc_back
	import svalloc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	input  cmd_t     cmd,
	output logic     cmd_take,
	output logic     res_push,
	output res_t     res_data,
	input  logic     res_full,
	output bk_stat_t stat
);

	bk_state_t         state_q;
	bk_state_t         state_d;
	logic [VOICE_COUNT-1:0] busy_q;
	logic [CHAN_W-1:0] owner_q [VOICE_COUNT];
	logic [NOTE_W-1:0] note_q  [VOICE_COUNT];
	logic [AGE_W-1:0]  age_q   [VOICE_COUNT];
	logic [AGE_W-1:0]  age_ctr_q;
	logic [VSEL_W-1:0] idx_q;
	logic [VSEL_W-1:0] pick_q;
	logic [AGE_W-1:0]  best_q;
	logic              pend_valid_q;
	logic [VSEL_W-1:0] pend_voice_q;
	cmd_t              cur_q;

	logic              busy_i;
	logic              match_i;
	logic              last_idx;
	logic              advance;
	logic [AGE_W-1:0]  age_next;

	assign busy_i   = busy_q[idx_q];
	assign match_i  = busy_i && ((cur_q.op == OP_ALL_OFF) ||
		((owner_q[idx_q] == cur_q.channel) && (note_q[idx_q] == cur_q.note)));
	assign last_idx = (idx_q == VSEL_W'(VOICE_COUNT - 1));
	assign advance  = !(res_push && res_full);
	assign age_next = age_ctr_q + 1'b1;
	assign stat.idle = (state_q == BK_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					state_d = (cmd.op == OP_ALLOC) ? BK_ALLOC : BK_FREE;
				end
			end
			BK_ALLOC: begin
				if (!busy_i) begin
					state_d = BK_GRANT;
				end else if (last_idx) begin
					state_d = BK_STEAL;
				end
			end
			BK_STEAL: begin
				if (advance) begin
					state_d = BK_GRANT;
				end
			end
			BK_GRANT: begin
				if (advance) begin
					state_d = BK_IDLE;
				end
			end
			BK_FREE: begin
				if (advance && last_idx) begin
					state_d = BK_FLUSH;
				end
			end
			BK_FLUSH: begin
				if (advance) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// A released voice is held back one match so that the final one can carry last.
	always_comb begin
		cmd_take = 1'b0;
		res_push = 1'b0;
		res_data = '{voice: '0, action: ACT_GRANT, last: 1'b0};
		case (state_q)
			BK_IDLE: cmd_take = cmd_valid;
			BK_STEAL: begin
				res_push = 1'b1;
				res_data = '{voice: VOICE_W'(pick_q), action: ACT_STEAL, last: 1'b0};
			end
			BK_GRANT: begin
				res_push = 1'b1;
				res_data = '{voice: VOICE_W'(pick_q), action: ACT_GRANT, last: 1'b1};
			end
			BK_FREE: begin
				res_push = match_i && pend_valid_q;
				res_data = '{voice: VOICE_W'(pend_voice_q), action: ACT_RELEASE, last: 1'b0};
			end
			BK_FLUSH: begin
				res_push = pend_valid_q;
				res_data = '{voice: VOICE_W'(pend_voice_q), action: ACT_RELEASE, last: 1'b1};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			busy_q       <= '0;
			age_ctr_q    <= '0;
			idx_q        <= '0;
			pick_q       <= '0;
			best_q       <= '1;
			pend_valid_q <= 1'b0;
			pend_voice_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				BK_IDLE: begin
					if (cmd_valid) begin
						idx_q        <= '0;
						pick_q       <= '0;
						best_q       <= '1;
						pend_valid_q <= 1'b0;
					end
				end
				BK_ALLOC: begin
					if (!busy_i) begin
						pick_q <= idx_q;
					end else begin
						if (age_q[idx_q] < best_q) begin
							best_q <= age_q[idx_q];
							pick_q <= idx_q;
						end
						if (!last_idx) begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				BK_FREE: begin
					if (advance) begin
						if (match_i) begin
							busy_q[idx_q] <= 1'b0;
							pend_valid_q  <= 1'b1;
							pend_voice_q  <= idx_q;
						end
						if (!last_idx) begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				BK_GRANT: begin
					if (advance) begin
						busy_q[pick_q] <= 1'b1;
						age_ctr_q      <= age_next;
					end
				end
				default: ;
			endcase
		end
	end

	// Owner, note and age are only looked at while the busy bit is set.
	always_ff @(posedge clk) begin
		if (state_q == BK_GRANT && advance) begin
			owner_q[pick_q] <= cur_q.channel;
			note_q[pick_q]  <= cur_q.note;
			age_q[pick_q]   <= age_next;
		end
		if (state_q == BK_IDLE && cmd_valid) begin
			cur_q <= cmd;
		end
	end

endmodule

`default_nettype wire

// ----- sv/svalloc_resq.sv -----
// Result queue between the scan engine and the result port.
`default_nettype none

module svalloc_resq
	import svalloc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  res_t wr_data,
	output logic full,
	output logic empty,
	input  logic pop,
	output res_t head
);

	res_t               mem_q [RESQ_DEPTH];
	logic [RESQ_PW-1:0] wr_ptr_q;
	logic [RESQ_PW-1:0] rd_ptr_q;
	logic [RESQ_CW-1:0] count_q;
	logic               do_wr;
	logic               do_rd;

	assign full  = (count_q == RESQ_CW'(RESQ_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];
	assign do_wr = wr_en && !full;
	assign do_rd = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == RESQ_PW'(RESQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == RESQ_PW'(RESQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

// ----- sv/synth_voice_allocator_core.sv -----
// Voice allocator for a table of synthesizer voices. Requests enter through a queue-like port
// (push/full) and the voice events they cause leave through another (empty/pop), oldest first.
// An allocate request grants the lowest-numbered free voice; when every voice is busy it
// steals the busy voice with the smallest age (lowest index on ties), reporting the steal
// before the grant. Every grant stamps the voice with a 32-bit age counter that wraps. A
// release request frees each busy voice owned by the given channel and note, and all-off
// frees every busy voice; each freed voice gives one release event, and the last event of
// a request carries the last flag. A release that matches nothing gives no events, and the
// unused function code is accepted and dropped. The front end decodes requests into a
// two-entry command queue, so requests can be taken while the back end is still working.
// The back end works on one request at a time and walks the voice table one voice per
// clock: a release or all-off request scans every voice and then flushes its held event,
// and an allocate scans up to the first free voice and grants it, or scans every voice and
// reports a steal before the grant. A full result queue stalls the scan until the consumer pops.
// No clearing pass runs after reset; the block takes requests from the first cycle.
`default_nettype none

`include "synth_voice_allocator_core_macros.svh"

module synth_voice_allocator_core
	import svalloc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [FUNC_W-1:0]  func,
	input  logic [CHAN_W-1:0]  channel,
	input  logic [NOTE_W-1:0]  note,
	output logic               empty,
	input  logic               pop,
	output logic [VOICE_W-1:0] voice,
	output logic [1:0]         action,
	output logic               last
);

	// Command handoff between front and back end.
	logic     cmd_valid;
	cmd_t     cmd;
	logic     cmd_take;

	// Result handoff from the scan engine into the result queue.
	logic     res_push;
	res_t     res_data;
	logic     res_full;
	res_t     head;
	bk_stat_t bk_stat;

	svalloc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.func      (func),
		.channel   (channel),
		.note      (note),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	svalloc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.res_push  (res_push),
		.res_data  (res_data),
		.res_full  (res_full),
		.stat      (bk_stat)
	);

	svalloc_resq u_resq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_data),
		.full    (res_full),
		.empty   (empty),
		.pop     (pop),
		.head    (head)
	);

	assign voice  = head.voice;
	assign action = head.action;
	assign last   = head.last;

	// The scan engine must hold its event whenever the result queue has no room.
	`SVA_ASSERT_IMP(a_res_no_overflow, clk, arst_n, res_push && res_full, !bk_stat.idle, "event lost at full result queue")
	// With nothing queued and the engine idle, no event can appear out of thin air.
	`SVA_ASSERT_NXT(a_quiet_stays_empty, clk, arst_n, bk_stat.idle && !cmd_valid && empty && !push, empty, "spurious result event")
	// Every reported voice index lies inside the table.
	`SVA_ASSERT_IMP(a_voice_in_range, clk, arst_n, res_push, (VOICE_W+1)'(res_data.voice) < (VOICE_W+1)'(VOICE_COUNT), "voice index out of range")

endmodule

`default_nettype wire
